// ===== rtl/gmr_pkg.sv =====
// ----------------------------------------------------------------------------
// gmr_pkg
// Shared sizes, codes and types of the grid maze reachability block.
// ----------------------------------------------------------------------------
package gmr_pkg;

  localparam int GRID_ROWS  = 16;
  localparam int GRID_COLS  = 16;
  localparam int ROW_W      = $clog2(GRID_ROWS);
  localparam int COL_W      = $clog2(GRID_COLS);
  localparam int CELL_W     = ROW_W + COL_W;
  localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
  localparam int MAP_DEPTH  = 2 ** CELL_W;
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);

  localparam int COORD_W    = 4;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cell_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

endpackage

// ===== rtl/gmr_ram.sv =====
// ----------------------------------------------------------------------------
// gmr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gmr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gmr_stack_cell.sv =====
// ----------------------------------------------------------------------------
// gmr_stack_cell
// One entry of the shifting stack: takes the entry above on a push and the
// entry below on a pop.
// ----------------------------------------------------------------------------
module gmr_stack_cell (
  input  logic              clk_i,
  input  gmr_pkg::stk_op_t  op_i,
  input  gmr_pkg::cell_t    up_i,
  input  gmr_pkg::cell_t    dn_i,
  output gmr_pkg::cell_t    data_o
);

  gmr_pkg::cell_t data_q;

  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      data_q <= up_i;
    end else if (op_i.pop) begin
      data_q <= dn_i;
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/gmr_stack.sv =====
// ----------------------------------------------------------------------------
// gmr_stack
// Cell stack built as a chain of shifting cells; the top sits in the first
// cell, and a fill count tracks the depth.
// ----------------------------------------------------------------------------
module gmr_stack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  gmr_pkg::stk_op_t   op_i,
  input  gmr_pkg::cell_t     push_data_i,
  output gmr_pkg::cell_t     top_o,
  output gmr_pkg::stk_stat_t status_o
);

  localparam int Depth = gmr_pkg::CELL_COUNT;

  logic [gmr_pkg::CNT_W-1:0] count_q, count_d;
  gmr_pkg::stk_op_t          op;
  gmr_pkg::cell_t            data [Depth];

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == gmr_pkg::CNT_W'(Depth));

  assign op.push = op_i.push & ~status_o.full;
  assign op.pop  = op_i.pop & ~op_i.push & ~status_o.empty;

  always_comb begin
    count_d = count_q;
    if (clear_i) begin
      count_d = '0;
    end else if (op.push) begin
      count_d = count_q + gmr_pkg::CNT_W'(1);
    end else if (op.pop) begin
      count_d = count_q - gmr_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    gmr_pkg::cell_t up;
    gmr_pkg::cell_t dn;

    if (i == 0) begin : g_first
      assign up = push_data_i;
    end else begin : g_mid
      assign up = data[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign dn = '0;
    end else begin : g_inner
      assign dn = data[i+1];
    end

    gmr_stack_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .up_i   (up),
      .dn_i   (dn),
      .data_o (data[i])
    );
  end

  assign top_o = data[0];

endmodule

// ===== rtl/grid_maze_reachability.sv =====
// ----------------------------------------------------------------------------
// grid_maze_reachability
// Grid maze wall map with a depth-first reachability query.
// ----------------------------------------------------------------------------
// A beat with tuser = 0 writes one cell's wall bit and gives no result; a cell
// outside the grid is ignored. A beat with tuser = 1 runs a query and gives one
// result beat: found = 1 when the end cell is reachable from the start through
// open 4-connected cells. The input takes no beat while a query runs. A query
// accepts the beat and checks the end cell, clears the visited marks and the
// stack, pushes the start cell, then for every cell it pops issues one map read
// for each of the four neighbors, one per cycle through the single read ports,
// and ends with the final pop and handing over the result; when the end is a
// wall it skips the search and hands over the result. The stack is a chain of
// shifting cells, so every entry moves at once on a pop or a push. After reset
// the wall map reads as all open at once.
// ----------------------------------------------------------------------------
module grid_maze_reachability (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // row[3:0], col[7:4], wall[8], end_row[12:9], end_col[16:13], zero pad
  input  logic [gmr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // kind[0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // found[0], zero pad
  output logic [gmr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_END,
    ST_CLEAR,
    ST_START,
    ST_POP,
    ST_EXPAND,
    ST_RESULT
  } state_e;

  typedef enum logic [1:0] {
    DIR_N,
    DIR_E,
    DIR_S,
    DIR_W
  } dir_e;

  typedef struct packed {
    logic           ok;
    gmr_pkg::cell_t pos;
  } nb_t;

  localparam int MapD = gmr_pkg::MAP_DEPTH;
  localparam int CW   = gmr_pkg::CELL_W;
  localparam int RW   = gmr_pkg::ROW_W;
  localparam int KW   = gmr_pkg::COL_W;

  function automatic nb_t neighbor(gmr_pkg::cell_t c, dir_e d);
    nb_t n;
    n = '{ok: 1'b0, pos: c};
    unique case (d)
      DIR_N: begin
        n.ok      = (c.row != '0);
        n.pos.row = c.row - RW'(1);
      end
      DIR_E: begin
        n.ok      = (c.col != KW'(gmr_pkg::GRID_COLS - 1));
        n.pos.col = c.col + KW'(1);
      end
      DIR_S: begin
        n.ok      = (c.row != RW'(gmr_pkg::GRID_ROWS - 1));
        n.pos.row = c.row + RW'(1);
      end
      DIR_W: begin
        n.ok      = (c.col != '0);
        n.pos.col = c.col - KW'(1);
      end
      default: n = '{ok: 1'b0, pos: c};
    endcase
    return n;
  endfunction

  function automatic nb_t in_coord(logic [gmr_pkg::COORD_W-1:0] r,
                                   logic [gmr_pkg::COORD_W-1:0] c);
    logic [6:0] re;
    logic [6:0] ce;
    nb_t        n;
    re      = {3'b000, r};
    ce      = {3'b000, c};
    n.ok    = (re < 7'(gmr_pkg::GRID_ROWS)) && (ce < 7'(gmr_pkg::GRID_COLS));
    n.pos   = '{row: re[RW-1:0], col: ce[KW-1:0]};
    return n;
  endfunction

  state_e             state_q, state_d;
  dir_e               dir_q, dir_d;
  gmr_pkg::cell_t     cur_q, cur_d;
  gmr_pkg::cell_t     cand_q, cand_d;
  logic               cand_ok_q, cand_ok_d;
  logic               rd_wv_q, rd_wv_d;
  gmr_pkg::cell_t     goal_q, goal_d;
  gmr_pkg::cell_t     start_q, start_d;
  logic               found_q, found_d;
  logic               out_valid_q, out_valid_d;
  logic               out_found_q, out_found_d;
  logic [CW-1:0]      clr_q, clr_d;
  logic [MapD-1:0]    wvalid_q, wvalid_d;

  logic               ram_we;
  logic [CW-1:0]      ram_waddr;
  logic               ram_wdata;
  logic [CW-1:0]      ram_raddr;
  logic               ram_rdata;

  logic               vis_we;
  logic [CW-1:0]      vis_waddr;
  logic               vis_wdata;
  logic               vis_rdata;

  gmr_pkg::stk_op_t   stk_op;
  logic               stk_clear;
  gmr_pkg::cell_t     stk_top;
  gmr_pkg::stk_stat_t stk_stat;

  nb_t                in_a;
  nb_t                in_b;
  nb_t                nb;
  logic               cand_wall;

  assign in_a = in_coord(s_axis_tdata[3:0], s_axis_tdata[7:4]);
  assign in_b = in_coord(s_axis_tdata[12:9], s_axis_tdata[16:13]);
  assign cand_wall = rd_wv_q & ram_rdata;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(gmr_pkg::OUT_DATA_W-1){1'b0}}, out_found_q};

  always_comb begin
    state_d     = state_q;
    dir_d       = dir_q;
    cur_d       = cur_q;
    cand_d      = cand_q;
    cand_ok_d   = cand_ok_q;
    rd_wv_d     = rd_wv_q;
    goal_d      = goal_q;
    start_d     = start_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    clr_d       = clr_q;
    wvalid_d    = wvalid_q;
    ram_we      = 1'b0;
    ram_waddr   = in_a.pos;
    ram_wdata   = s_axis_tdata[8];
    ram_raddr   = cand_q;
    vis_we      = 1'b0;
    vis_waddr   = cand_q;
    vis_wdata   = 1'b1;
    stk_op      = '{push: 1'b0, pop: 1'b0};
    stk_clear   = 1'b0;
    nb          = '{ok: 1'b0, pos: cur_q};

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == gmr_pkg::KIND_LOAD) begin
            if (in_a.ok) begin
              ram_we             = 1'b1;
              wvalid_d[in_a.pos] = 1'b1;
            end
          end else begin
            start_d = in_a.pos;
            goal_d  = in_b.pos;
            if (!in_a.ok || !in_b.ok) begin
              found_d = 1'b0;
              state_d = ST_RESULT;
            end else begin
              ram_raddr = in_b.pos;
              rd_wv_d   = wvalid_q[in_b.pos];
              state_d   = ST_CHK_END;
            end
          end
        end
      end
      ST_CHK_END: begin
        if (cand_wall) begin
          found_d = 1'b0;
          state_d = ST_RESULT;
        end else begin
          ram_raddr = start_q;
          rd_wv_d   = wvalid_q[start_q];
          cand_d    = start_q;
          cand_ok_d = 1'b1;
          clr_d     = '0;
          state_d   = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        // wall map keeps reading the start cell meanwhile
        stk_clear = 1'b1;
        vis_we    = 1'b1;
        vis_waddr = clr_q;
        vis_wdata = 1'b0;
        clr_d     = clr_q + CW'(1);
        if (clr_q == CW'(MapD - 1)) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (cand_ok_q && !cand_wall && !stk_stat.full) begin
          stk_op.push = 1'b1;
          vis_we      = 1'b1;
        end
        state_d = ST_POP;
      end
      ST_POP: begin
        if (stk_stat.empty) begin
          found_d = 1'b0;
          state_d = ST_RESULT;
        end else begin
          stk_op.pop = 1'b1;
          cur_d      = stk_top;
          if (stk_top == goal_q) begin
            found_d = 1'b1;
            state_d = ST_RESULT;
          end else begin
            nb        = neighbor(stk_top, DIR_N);
            ram_raddr = nb.pos;
            rd_wv_d   = wvalid_q[nb.pos];
            cand_d    = nb.pos;
            cand_ok_d = nb.ok;
            dir_d     = DIR_N;
            state_d   = ST_EXPAND;
          end
        end
      end
      ST_EXPAND: begin
        if (cand_ok_q && !cand_wall && !vis_rdata && !stk_stat.full) begin
          stk_op.push = 1'b1;
          vis_we      = 1'b1;
        end
        if (dir_q == DIR_W) begin
          state_d = ST_POP;
        end else begin
          unique case (dir_q)
            DIR_N:   dir_d = DIR_E;
            DIR_E:   dir_d = DIR_S;
            default: dir_d = DIR_W;
          endcase
          nb        = neighbor(cur_q, dir_d);
          ram_raddr = nb.pos;
          rd_wv_d   = wvalid_q[nb.pos];
          cand_d    = nb.pos;
          cand_ok_d = nb.ok;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_found_d = found_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dir_q       <= DIR_N;
      out_valid_q <= 1'b0;
      wvalid_q    <= '0;
    end else begin
      state_q     <= state_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
      wvalid_q    <= wvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    cand_q      <= cand_d;
    cand_ok_q   <= cand_ok_d;
    rd_wv_q     <= rd_wv_d;
    goal_q      <= goal_d;
    start_q     <= start_d;
    found_q     <= found_d;
    out_found_q <= out_found_d;
    clr_q       <= clr_d;
  end

  gmr_ram #(
    .WIDTH (1),
    .DEPTH (MapD)
  ) u_wall_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  gmr_ram #(
    .WIDTH (1),
    .DEPTH (MapD)
  ) u_visited_ram (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (vis_rdata)
  );

  gmr_stack u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (stk_clear),
    .op_i        (stk_op),
    .push_data_i (cand_q),
    .top_o       (stk_top),
    .status_o    (stk_stat)
  );

endmodule

// ===== tb/sv/tb_grid_maze_reachability.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_maze_reachability
// Self-checking bench for the grid maze wall map and its reachability query.
// ----------------------------------------------------------------------------
// Loads and queries go in on the input stream. A local copy of the wall map
// is kept, and every accepted query is answered by an independent depth-first
// search over that copy. Each result beat is compared with the oldest
// pending answer. A directed pass covers corners, edges, walls on the start
// or end, start equal to end and blocked corners that would leak if the
// grid wrapped. Random rounds then build mazes out of scattered walls and
// full wall lines with gaps, and query them. Both stream sides stall at
// random, apart from one stretch that runs without gaps.
// ----------------------------------------------------------------------------
module tb_grid_maze_reachability;
  import gmr_pkg::*;

  localparam int      RESET_CYCLES  = 12;
  localparam int      SETTLE_CYCLES = 64;
  localparam int      RANDOM_ITEMS  = 560;
  localparam int      STEADY_ITEMS  = 40;
  localparam longint  CYCLE_LIMIT   = 6_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  bit     maze_walls [CELL_COUNT];
  bit     pending_found [$];
  bit     steady;
  int     errors;
  int     items_sent;
  int     loads_sent;
  int     queries_sent;
  int     reachable_seen;
  int     blocked_seen;
  longint cycle_count;

  grid_maze_reachability dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic bit maze_reachable(input logic [COORD_W-1:0] sr,
                                        input logic [COORD_W-1:0] sc,
                                        input logic [COORD_W-1:0] er,
                                        input logic [COORD_W-1:0] ec);
    bit    seen [CELL_COUNT];
    cell_t trail [CELL_COUNT];
    int    depth;
    cell_t cur;
    cell_t nb;
    cell_t goal;
    bit    ok;
    if (sr >= GRID_ROWS || sc >= GRID_COLS || er >= GRID_ROWS || ec >= GRID_COLS) return 1'b0;
    cur.row  = sr[ROW_W-1:0];
    cur.col  = sc[COL_W-1:0];
    goal.row = er[ROW_W-1:0];
    goal.col = ec[COL_W-1:0];
    if (maze_walls[cur] || maze_walls[goal]) return 1'b0;
    seen[cur] = 1'b1;
    trail[0]  = cur;
    depth     = 1;
    while (depth > 0) begin
      depth--;
      cur = trail[depth];
      if (cur == goal) return 1'b1;
      for (int dir = 0; dir < 4; dir++) begin
        ok = 1'b1;
        nb = cur;
        case (dir)
          0: if (cur.row == 0) ok = 1'b0; else nb.row = cur.row - 1'b1;
          1: if (cur.col == GRID_COLS - 1) ok = 1'b0; else nb.col = cur.col + 1'b1;
          2: if (cur.row == GRID_ROWS - 1) ok = 1'b0; else nb.row = cur.row + 1'b1;
          default: if (cur.col == 0) ok = 1'b0; else nb.col = cur.col - 1'b1;
        endcase
        if (ok && !maze_walls[nb] && !seen[nb] && depth < CELL_COUNT) begin
          seen[nb]     = 1'b1;
          trail[depth] = nb;
          depth++;
        end
      end
    end
    return 1'b0;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(input logic kind, input logic [COORD_W-1:0] row,
                           input logic [COORD_W-1:0] col, input logic wall,
                           input logic [COORD_W-1:0] end_row,
                           input logic [COORD_W-1:0] end_col);
    cell_t target;
    while (!steady && $urandom_range(99) < 36) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = {7'b0, end_col, end_row, wall, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (kind == KIND_LOAD) begin
      loads_sent++;
      if (row < GRID_ROWS && col < GRID_COLS) begin
        target.row = row[ROW_W-1:0];
        target.col = col[COL_W-1:0];
        maze_walls[target] = wall;
      end
    end else begin
      queries_sent++;
      pending_found.push_back(maze_reachable(row, col, end_row, end_col));
    end
    @(negedge clk_i);
  endtask

  task automatic hold_off();
    s_axis_tvalid = 1'b0;
    while (pending_found.size() != 0) @(negedge clk_i);
  endtask

  task automatic random_load(input int density);
    send_beat(KIND_LOAD, COORD_W'($urandom_range(15)), COORD_W'($urandom_range(15)),
              $urandom_range(99) < density, COORD_W'($urandom_range(15)),
              COORD_W'($urandom_range(15)));
  endtask

  task automatic random_query();
    logic [COORD_W-1:0] sr, sc, er, ec;
    sr = COORD_W'($urandom_range(15));
    sc = COORD_W'($urandom_range(15));
    er = COORD_W'($urandom_range(15));
    ec = COORD_W'($urandom_range(15));
    if ($urandom_range(99) < 15) begin
      er = sr;
      ec = sc;
    end else if ($urandom_range(99) < 20) begin
      sr = {COORD_W{1'($urandom_range(1))}};
      sc = {COORD_W{1'($urandom_range(1))}};
    end
    send_beat(KIND_QUERY, sr, sc, 1'($urandom_range(1)), er, ec);
  endtask

  task automatic test_directed_cases();
    send_beat(KIND_QUERY, 0, 0, 0, 15, 15);
    send_beat(KIND_QUERY, 15, 15, 1, 0, 0);
    send_beat(KIND_QUERY, 9, 6, 0, 9, 6);
    send_beat(KIND_LOAD, 15, 15, 1, 15, 15);
    send_beat(KIND_QUERY, 0, 0, 0, 15, 15);
    send_beat(KIND_QUERY, 15, 15, 0, 0, 0);
    send_beat(KIND_QUERY, 15, 15, 1, 15, 15);
    // box in the top-left corner
    send_beat(KIND_LOAD, 0, 1, 1, 0, 0);
    send_beat(KIND_LOAD, 1, 0, 1, 15, 15);
    send_beat(KIND_QUERY, 0, 0, 0, 3, 12);
    send_beat(KIND_QUERY, 0, 0, 1, 0, 0);
    send_beat(KIND_QUERY, 0, 15, 0, 15, 0);
    send_beat(KIND_LOAD, 0, 1, 0, 7, 7);
    send_beat(KIND_QUERY, 0, 0, 0, 15, 14);
    // box in the bottom-left corner; a wrapping walk would reach row 14 col 15
    send_beat(KIND_LOAD, 14, 0, 1, 0, 15);
    send_beat(KIND_LOAD, 15, 1, 1, 15, 0);
    send_beat(KIND_QUERY, 15, 0, 0, 14, 15);
    send_beat(KIND_QUERY, 14, 15, 1, 15, 0);
    send_beat(KIND_LOAD, 15, 15, 0, 0, 0);
    send_beat(KIND_LOAD, 1, 0, 0, 0, 0);
    send_beat(KIND_LOAD, 14, 0, 0, 0, 0);
    send_beat(KIND_LOAD, 15, 1, 0, 0, 0);
    send_beat(KIND_QUERY, 15, 0, 0, 0, 15);
  endtask

  task automatic test_pressure_drain();
    repeat (3) random_query();
    hold_off();
    @(negedge clk_i);
    random_load(50);
    random_query();
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    repeat (STEADY_ITEMS) begin
      if ($urandom_range(99) < 70) random_load(35);
      else random_query();
    end
    steady = 1'b0;
  endtask

  task automatic test_random_mazes();
    int                 density;
    int                 gap;
    logic [COORD_W-1:0] line;
    bit                 vertical;
    while (items_sent < RANDOM_ITEMS) begin
      density = $urandom_range(4) * 15;
      if ($urandom_range(3) == 0) begin
        // full wall line with one gap
        line     = COORD_W'($urandom_range(15));
        gap      = $urandom_range(15);
        vertical = 1'($urandom_range(1));
        for (int i = 0; i < GRID_ROWS; i++) begin
          if (vertical) send_beat(KIND_LOAD, COORD_W'(i), line, i != gap,
                                  COORD_W'($urandom_range(15)), 0);
          else send_beat(KIND_LOAD, line, COORD_W'(i), i != gap, 0,
                         COORD_W'($urandom_range(15)));
        end
      end else begin
        repeat ($urandom_range(24, 3)) random_load(density);
      end
      repeat ($urandom_range(5, 1)) random_query();
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = steady || ($urandom_range(99) >= 36);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (pending_found.size() == 0) begin
          $error("unexpected result beat, found=%0d", m_axis_tdata[0]);
          errors++;
        end else begin
          if (m_axis_tdata[0] !== pending_found[0]) begin
            $error("found mismatch: expected %0d, actual %0d", pending_found[0],
                   m_axis_tdata[0]);
            errors++;
          end
          if (m_axis_tdata[OUT_DATA_W-1:1] !== '0) begin
            $error("pad mismatch: expected 0, actual %0h", m_axis_tdata[OUT_DATA_W-1:1]);
            errors++;
          end
          if (pending_found[0]) reachable_seen++;
          else blocked_seen++;
          void'(pending_found.pop_front());
        end
      end
    end
  end

  initial begin
    cycle_count   = 0;
    errors        = 0;
    steady        = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = KIND_LOAD;
    s_axis_tdata  = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_pressure_drain();
    test_steady_stream();
    test_random_mazes();

    hold_off();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (pending_found.size() != 0) begin
      $error("%0d results never arrived", pending_found.size());
      errors++;
    end
    $display("sent %0d loads and %0d queries in %0d cycles", loads_sent, queries_sent,
             cycle_count);
    $display("answers checked: %0d reachable, %0d blocked", reachable_seen, blocked_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
